@@ hw/rtl/double_ended_queue_unit_macros.svh @@
// Assertion macros for the double-ended queue unit.
// Included by the top level; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue unit.
// No dependencies.
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } t_deq_in;

    typedef struct packed {
        logic [1:0]               status;
        logic                     is_empty;
        logic [CNT_W-1:0]         entry_count;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
    } t_deq_out;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr_front;
        logic [IDX_W-1:0]  raddr_rear;
    } t_deq_mem_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } t_deq_meta;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(idx - 1'b1);
    endfunction

endpackage

@@ hw/rtl/deq_ram.sv @@
// Generic memory with one write port and two registered read ports.
// No dependencies; a read at the written address returns the old data.
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// Front index, rear index and count of the ring, and the memory requests per operation.
// Depends on deq_pkg.
module deq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  deq_pkg::t_deq_in      i_cmd,
    output deq_pkg::t_deq_mem_req o_req,
    output deq_pkg::t_deq_meta    o_meta
);

    logic [deq_pkg::IDX_W-1:0] r_front, n_front;
    logic [deq_pkg::IDX_W-1:0] r_rear, n_rear;
    logic [deq_pkg::CNT_W-1:0] r_count, n_count;
    logic                      full, empty, we;
    logic [deq_pkg::IDX_W-1:0] waddr;
    logic [1:0]                status;

    assign full  = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        n_front = r_front;
        n_rear  = r_rear;
        n_count = r_count;
        we      = 1'b0;
        waddr   = r_rear;
        status  = deq_pkg::ST_DONE;
        unique case (i_cmd.mode)
            deq_pkg::MODE_PUSH_FRONT: begin
                if (full) begin
                    status = deq_pkg::ST_FULL;
                end else begin
                    n_front = deq_pkg::idx_dec(r_front);
                    waddr   = n_front;
                    we      = 1'b1;
                    n_count = deq_pkg::CNT_W'(r_count + 1'b1);
                end
            end
            deq_pkg::MODE_PUSH_REAR: begin
                if (full) begin
                    status = deq_pkg::ST_FULL;
                end else begin
                    waddr   = r_rear;
                    we      = 1'b1;
                    n_rear  = deq_pkg::idx_inc(r_rear);
                    n_count = deq_pkg::CNT_W'(r_count + 1'b1);
                end
            end
            deq_pkg::MODE_POP_FRONT: begin
                if (empty) begin
                    status = deq_pkg::ST_EMPTY;
                end else begin
                    n_front = deq_pkg::idx_inc(r_front);
                    n_count = deq_pkg::CNT_W'(r_count - 1'b1);
                end
            end
            deq_pkg::MODE_POP_REAR: begin
                if (empty) begin
                    status = deq_pkg::ST_EMPTY;
                end else begin
                    n_rear  = deq_pkg::idx_dec(r_rear);
                    n_count = deq_pkg::CNT_W'(r_count - 1'b1);
                end
            end
            default: begin
                status = deq_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_rear  <= n_rear;
            r_count <= n_count;
        end
    end

    assign o_req.we          = we & i_accept;
    assign o_req.waddr       = waddr;
    assign o_req.wdata       = i_cmd.value;
    assign o_req.raddr_front = n_front;
    assign o_req.raddr_rear  = deq_pkg::idx_dec(n_rear);
    assign o_meta.status     = status;
    assign o_meta.count      = n_count;

endmodule

@@ hw/rtl/double_ended_queue_unit.sv @@
// Top level of the double-ended queue unit: ring control, entry memory and result register.
// Depends on deq_pkg, deq_ctrl, deq_ram and double_ended_queue_unit_macros.svh.
// The unit takes one operation in every clock cycle and never raises busy. The result of an
// operation appears with o_strobe in the cycle after its transfer, as the entry memory has a
// registered read; a write and a read of the same entry in the same cycle are forwarded.
// Results cannot be held off, so each must be taken in the cycle it is shown.
`include "double_ended_queue_unit_macros.svh"
module double_ended_queue_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::t_deq_in  i_cmd,
    output logic              o_strobe,
    output deq_pkg::t_deq_out o_result
);

    logic                       accept;
    deq_pkg::t_deq_mem_req      req;
    deq_pkg::t_deq_meta         meta;
    logic [deq_pkg::DATA_W-1:0] rdata_front, rdata_rear;
    logic                       r_strobe;
    logic [1:0]                 r_status;
    logic [deq_pkg::CNT_W-1:0]  r_count;
    logic                       r_fwd_front, r_fwd_rear;
    logic [deq_pkg::DATA_W-1:0] r_fwd_data;
    logic [deq_pkg::DATA_W-1:0] front_data, rear_data;
    logic                       is_empty;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_cmd),
        .o_req    (req),
        .o_meta   (meta)
    );

    deq_ram #(
        .DEPTH (deq_pkg::DEPTH),
        .WIDTH (deq_pkg::DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (req.we),
        .i_waddr   (req.waddr),
        .i_wdata   (req.wdata),
        .i_raddr_a (req.raddr_front),
        .i_raddr_b (req.raddr_rear),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_rear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= meta.status;
            r_count  <= meta.count;
        end
        r_fwd_front <= req.we && (req.waddr == req.raddr_front);
        r_fwd_rear  <= req.we && (req.waddr == req.raddr_rear);
        r_fwd_data  <= req.wdata;
    end

    assign is_empty   = (r_count == '0);
    assign front_data = r_fwd_front ? r_fwd_data : rdata_front;
    assign rear_data  = r_fwd_rear ? r_fwd_data : rdata_rear;

    assign o_strobe             = r_strobe;
    assign o_result.status      = r_status;
    assign o_result.is_empty    = is_empty;
    assign o_result.entry_count = r_count;
    assign o_result.front_value = is_empty ? '1 : front_data;
    assign o_result.rear_value  = is_empty ? '1 : rear_data;

    `DEQ_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, o_strobe)
    `DEQ_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !accept, !o_strobe)
    `DEQ_ASSERT_IMP(a_full_count, i_clk, i_rst_n, o_strobe && (o_result.status == deq_pkg::ST_FULL), o_result.entry_count == deq_pkg::CNT_W'(deq_pkg::DEPTH))
    `DEQ_ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, o_strobe && (o_result.status == deq_pkg::ST_EMPTY), o_result.is_empty)

endmodule

@@ tb/double_ended_queue_unit_test.sv @@
// Self-checking testbench for double_ended_queue_unit: directed table, then random push/pop runs.
// o_result is compared with a ring model in this file, or with the result pinned in a table row.
// Depends on deq_pkg and the double_ended_queue_unit RTL.
module double_ended_queue_unit_test;

    localparam int RANDOM_OPS = 1120;
    localparam int CALM_TAIL  = 150;

    typedef struct {
        logic [1:0]                        mode;
        logic signed [deq_pkg::DATA_W-1:0] value;
        int                                reps;
        bit                                pinned;
        deq_pkg::t_deq_out                 res;
    } t_op_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    deq_pkg::t_deq_in  i_cmd;
    logic              o_strobe;
    deq_pkg::t_deq_out o_result;

    logic              pinned_valid;
    deq_pkg::t_deq_out pinned_result;

    logic signed [deq_pkg::DATA_W-1:0] model_ring [deq_pkg::DEPTH];
    int                                model_front;
    int                                model_rear;
    int                                model_count;

    deq_pkg::t_deq_out awaited_results [$];
    int                fault_count;

    double_ended_queue_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("double_ended_queue_unit_test: FAIL");
        $finish;
    end

    function automatic deq_pkg::t_deq_out apply_deque_op(input deq_pkg::t_deq_in cmd);
        deq_pkg::t_deq_out res;
        res = '0;
        res.status = deq_pkg::ST_DONE;
        if (cmd.mode == deq_pkg::MODE_PUSH_FRONT || cmd.mode == deq_pkg::MODE_PUSH_REAR) begin
            if (model_count >= deq_pkg::DEPTH) begin
                res.status = deq_pkg::ST_FULL;
            end else if (cmd.mode == deq_pkg::MODE_PUSH_FRONT) begin
                model_front = (model_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                model_ring[model_front] = cmd.value;
                model_count++;
            end else begin
                model_ring[model_rear] = cmd.value;
                model_rear = (model_rear + 1) % deq_pkg::DEPTH;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                res.status = deq_pkg::ST_EMPTY;
            end else if (cmd.mode == deq_pkg::MODE_POP_FRONT) begin
                model_front = (model_front + 1) % deq_pkg::DEPTH;
                model_count--;
            end else begin
                model_rear = (model_rear + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                model_count--;
            end
        end
        res.is_empty = (model_count == 0);
        res.entry_count = deq_pkg::CNT_W'(model_count);
        if (model_count == 0) begin
            res.front_value = '1;
            res.rear_value = '1;
        end else begin
            res.front_value = model_ring[model_front];
            res.rear_value = model_ring[(model_rear + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        deq_pkg::t_deq_out predicted;
        deq_pkg::t_deq_out wanted;
        if (i_rst_n) begin
            if (start && !busy) begin
                predicted = apply_deque_op(i_cmd);
                awaited_results.push_back(pinned_valid ? pinned_result : predicted);
            end
            if (o_strobe) begin
                if (awaited_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("Unexpected result: status=%0d empty=%0d count=%0d %s",
                                 o_result.status, o_result.is_empty, o_result.entry_count,
                                 $sformatf("front=%h rear=%h",
                                           o_result.front_value, o_result.rear_value));
                    end
                end else begin
                    wanted = awaited_results.pop_front();
                    if (o_result.status !== wanted.status
                        || o_result.is_empty !== wanted.is_empty
                        || o_result.entry_count !== wanted.entry_count
                        || o_result.front_value !== wanted.front_value
                        || o_result.rear_value !== wanted.rear_value) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("Mismatch: expected status=%0d empty=%0d count=%0d %s",
                                     wanted.status, wanted.is_empty, wanted.entry_count,
                                     $sformatf("front=%h rear=%h",
                                               wanted.front_value, wanted.rear_value));
                            $display("          actual   status=%0d empty=%0d count=%0d %s",
                                     o_result.status, o_result.is_empty, o_result.entry_count,
                                     $sformatf("front=%h rear=%h",
                                               o_result.front_value, o_result.rear_value));
                        end
                    end
                end
            end
        end
    end

    task automatic issue_op(input deq_pkg::t_deq_in cmd, input bit pin,
                            input deq_pkg::t_deq_out pin_res);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= cmd;
        pinned_valid <= pin;
        pinned_result <= pin_res;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
            pinned_valid <= 1'b0;
            i_cmd <= {2'($urandom_range(0, 3)), deq_pkg::DATA_W'($urandom)};
        end
    endtask

    t_op_row directed_rows [14] = '{
        '{deq_pkg::MODE_POP_FRONT,  32'sh0000_0000, 1, 1'b1,
          '{deq_pkg::ST_EMPTY, 1'b1, deq_pkg::CNT_W'(0), 32'shFFFF_FFFF, 32'shFFFF_FFFF}},
        '{deq_pkg::MODE_POP_REAR,   32'sh0000_0000, 1, 1'b1,
          '{deq_pkg::ST_EMPTY, 1'b1, deq_pkg::CNT_W'(0), 32'shFFFF_FFFF, 32'shFFFF_FFFF}},
        '{deq_pkg::MODE_PUSH_FRONT, 32'sh7FFF_FFFF, 1, 1'b1,
          '{deq_pkg::ST_DONE, 1'b0, deq_pkg::CNT_W'(1), 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}},
        '{deq_pkg::MODE_PUSH_REAR,  32'sh8000_0000, 1, 1'b1,
          '{deq_pkg::ST_DONE, 1'b0, deq_pkg::CNT_W'(2), 32'sh7FFF_FFFF, 32'sh8000_0000}},
        '{deq_pkg::MODE_PUSH_FRONT, 32'shFFFF_FFFF, 1, 1'b0, '0},
        '{deq_pkg::MODE_POP_REAR,   32'sh0000_0000, 1, 1'b0, '0},
        '{deq_pkg::MODE_POP_FRONT,  32'sh0000_0000, 1, 1'b0, '0},
        '{deq_pkg::MODE_POP_REAR,   32'sh0000_0000, 1, 1'b1,
          '{deq_pkg::ST_DONE, 1'b1, deq_pkg::CNT_W'(0), 32'shFFFF_FFFF, 32'shFFFF_FFFF}},
        '{deq_pkg::MODE_PUSH_FRONT, 32'sh0000_0000, 1, 1'b0, '0},
        '{deq_pkg::MODE_PUSH_REAR,  32'sh1234_0000, 15, 1'b0, '0},
        '{deq_pkg::MODE_PUSH_REAR,  32'sh5555_5555, 1, 1'b0, '0},
        '{deq_pkg::MODE_PUSH_FRONT, 32'shAAAA_AAAA, 1, 1'b0, '0},
        '{deq_pkg::MODE_POP_FRONT,  32'sh0000_0000, 1, 1'b0, '0},
        '{deq_pkg::MODE_POP_REAR,   32'sh0000_0000, 1, 1'b0, '0}
    };

    initial begin
        deq_pkg::t_deq_in cmd;
        int               issued;
        int               push_pct;
        int               run_len;
        int               waited;
        bit               noise;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        pinned_valid = 1'b0;
        pinned_result = '0;
        fault_count = 0;
        model_front = 0;
        model_rear = 0;
        model_count = 0;
        for (int k = 0; k < deq_pkg::DEPTH; k++) model_ring[k] = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                cmd.mode = directed_rows[r].mode;
                cmd.value = directed_rows[r].value + k;
                issue_op(cmd, directed_rows[r].pinned, directed_rows[r].res);
            end
        end

        // Runs of pushes or pops with a random bias fill and drain the ring, so
        // both the full and the empty boundary are crossed many times.
        issued = 0;
        while (issued < RANDOM_OPS) begin
            noise = ($urandom_range(0, 9) == 0);
            push_pct = $urandom_range(10, 90);
            run_len = $urandom_range(8, 40);
            for (int k = 0; k < run_len && issued < RANDOM_OPS; k++) begin
                if (issued < RANDOM_OPS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
                    hold_off($urandom_range(1, 17));
                end
                if (noise) begin
                    cmd.mode = 2'($urandom_range(0, 3));
                end else if ($urandom_range(0, 99) < push_pct) begin
                    cmd.mode = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_FRONT
                                                    : deq_pkg::MODE_PUSH_REAR;
                end else begin
                    cmd.mode = $urandom_range(0, 1) ? deq_pkg::MODE_POP_FRONT
                                                    : deq_pkg::MODE_POP_REAR;
                end
                case ($urandom_range(0, 7))
                    0: cmd.value = 32'sh7FFF_FFFF;
                    1: cmd.value = 32'sh8000_0000;
                    2: cmd.value = 32'shFFFF_FFFF;
                    3: cmd.value = 32'sh0000_0000;
                    default: cmd.value = deq_pkg::DATA_W'($urandom);
                endcase
                issue_op(cmd, 1'b0, '0);
                issued++;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        pinned_valid <= 1'b0;

        waited = 0;
        while (awaited_results.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);

        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("double_ended_queue_unit_test: PASS");
        end else begin
            $display("double_ended_queue_unit_test: FAIL");
        end
        $finish;
    end

endmodule
